### rtl/qpht_pkg.sv
// Shared types, widths and codes for the quadratic probe hash table.
package qpht_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int KEY_W     = 31;
  localparam int SLOT_W    = 10;
  localparam int MOD_W     = 11;
  localparam int COEF_W    = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 2;
  localparam int LEN_W     = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE  = 2'd2;

  localparam logic [MOD_W-1:0]  MODULUS_RST = 11'd10;
  localparam logic [COEF_W-1:0] LINEAR_RST  = 8'd1;
  localparam logic [COEF_W-1:0] SQUARE_RST  = 8'd3;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [LEN_W-1:0] nbits;
    logic [MOD_W-1:0] modulus;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } rem_rsp_t;

endpackage

### rtl/qpht_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module qpht_rem (
  input  logic                clk,
  input  logic                rst_n,
  input  qpht_pkg::rem_req_t  req,
  output qpht_pkg::rem_rsp_t  rsp
);
  import qpht_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt;
  logic [KEY_W-1:0] sh_r, sh_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W:0]   trial;

  always_comb begin
    trial    = {rem_r, sh_r[KEY_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    mod_nxt  = mod_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      sh_nxt   = req.dividend;
      cnt_nxt  = req.nbits;
      mod_nxt  = req.modulus;
    end else if (busy_r) begin
      if (trial >= {1'b0, mod_r}) begin
        rem_nxt = MOD_W'(trial - {1'b0, mod_r});
      end else begin
        rem_nxt = MOD_W'(trial);
      end
      sh_nxt  = {sh_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r - LEN_W'(1);
      if (cnt_r == LEN_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### rtl/quadratic_probe_hash_table.sv
// Top level: open-addressing key table with quadratic probing.
// Each item: key, c1 and c2 are reduced modulo m in the bit-serial remainder unit, then a setup
// step, then up to m probes of a memory read and a compare each, then the output register.
// One item at a time: in_ready returns in the cycle that out_valid rises, and the response
// waits while a stalled result is held. A zero key, or an insert into a full table, goes from
// the accept straight to the response. Reset: synchronous; then a clearing pass zeroes every entry.
module quadratic_probe_hash_table #(
  parameter int TABLE_DEPTH = qpht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  qpht_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qpht_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [qpht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qpht_pkg::CFG_W-1:0]        cfg_data
);
  import qpht_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [MOD_W-1:0] DEPTH_CAP =
    (TABLE_DEPTH >= (1 << MOD_W)) ? {MOD_W{1'b1}} : MOD_W'(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_REM_K  = 4'd2;
  localparam logic [3:0] S_REM_C1 = 4'd3;
  localparam logic [3:0] S_REM_C2 = 4'd4;
  localparam logic [3:0] S_SETUP  = 4'd5;
  localparam logic [3:0] S_READ   = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  function automatic logic [MOD_W-1:0] addmod(input logic [MOD_W-1:0] a,
                                              input logic [MOD_W-1:0] b,
                                              input logic [MOD_W-1:0] m);
    logic [MOD_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, m}) begin
      return MOD_W'(t - {1'b0, m});
    end
    return MOD_W'(t);
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic [MOD_W-1:0]    cfg_mod_r, cfg_mod_nxt;
  logic [COEF_W-1:0]   cfg_c1_r, cfg_c1_nxt;
  logic [COEF_W-1:0]   cfg_c2_r, cfg_c2_nxt;
  logic [MOD_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic                start_r, start_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                mode_r, mode_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [MOD_W-1:0]    m_r, m_nxt;
  logic [MOD_W-1:0]    s_r, s_nxt;
  logic [MOD_W-1:0]    home_r, home_nxt;
  logic [MOD_W-1:0]    d_r, d_nxt;
  logic [MOD_W-1:0]    dd_r, dd_nxt;
  logic [MOD_W-1:0]    c1m_r, c1m_nxt;
  logic [MOD_W-1:0]    c2m_r, c2m_nxt;
  logic [MOD_W-1:0]    i_r, i_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic [KEY_W-1:0]    mem [TABLE_DEPTH];
  logic [KEY_W-1:0]    rd_data_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [KEY_W-1:0]    mem_wdata;
  logic [ADDR_W-1:0]   rd_addr;

  logic [MOD_W-1:0]    eff_m;
  logic                in_fire;
  logic                last_probe;
  rem_req_t            rem_req;
  rem_rsp_t            rem_rsp;

  qpht_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  always_comb begin
    if (cfg_mod_r == '0) begin
      eff_m = MOD_W'(1);
    end else if (cfg_mod_r > DEPTH_CAP) begin
      eff_m = DEPTH_CAP;
    end else begin
      eff_m = cfg_mod_r;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign last_probe  = (({1'b0, i_r} + (MOD_W+1)'(1)) == {1'b0, m_r});
  assign rd_addr     = ADDR_W'(s_r);

  always_comb begin
    rem_req.start   = start_r;
    rem_req.modulus = m_r;
    unique case (state_r)
      S_REM_C1: begin
        rem_req.dividend = {cfg_c1_r, {(KEY_W-COEF_W){1'b0}}};
        rem_req.nbits    = LEN_W'(COEF_W);
      end
      S_REM_C2: begin
        rem_req.dividend = {cfg_c2_r, {(KEY_W-COEF_W){1'b0}}};
        rem_req.nbits    = LEN_W'(COEF_W);
      end
      default: begin
        rem_req.dividend = key_r;
        rem_req.nbits    = LEN_W'(KEY_W);
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cfg_mod_nxt    = cfg_mod_r;
    cfg_c1_nxt     = cfg_c1_r;
    cfg_c2_nxt     = cfg_c2_r;
    count_nxt      = count_r;
    clr_nxt        = clr_r;
    start_nxt      = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    m_nxt          = m_r;
    s_nxt          = s_r;
    home_nxt       = home_r;
    d_nxt          = d_r;
    dd_nxt         = dd_r;
    c1m_nxt        = c1m_r;
    c2m_nxt        = c2m_r;
    i_nxt          = i_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    mem_we         = 1'b0;
    mem_waddr      = rd_addr;
    mem_wdata      = key_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS: cfg_mod_nxt = cfg_data[MOD_W-1:0];
        CFG_LINEAR:  cfg_c1_nxt  = cfg_data[COEF_W-1:0];
        CFG_SQUARE:  cfg_c2_nxt  = cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt     = in_data.mode;
          key_nxt      = in_data.key;
          m_nxt        = eff_m;
          res_slot_nxt = '0;
          if (in_data.key == '0) begin
            res_status_nxt = (in_data.mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end else if (in_data.mode == MODE_INSERT && count_r >= eff_m) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_REM_K;
          end
        end
      end
      S_REM_K: begin
        if (rem_rsp.done) begin
          s_nxt     = rem_rsp.rem;
          home_nxt  = rem_rsp.rem;
          start_nxt = 1'b1;
          state_nxt = S_REM_C1;
        end
      end
      S_REM_C1: begin
        if (rem_rsp.done) begin
          c1m_nxt   = rem_rsp.rem;
          start_nxt = 1'b1;
          state_nxt = S_REM_C2;
        end
      end
      S_REM_C2: begin
        if (rem_rsp.done) begin
          c2m_nxt   = rem_rsp.rem;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        d_nxt     = addmod(c1m_r, c2m_r, m_r);
        dd_nxt    = addmod(c2m_r, c2m_r, m_r);
        i_nxt     = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (mode_r == MODE_INSERT && rd_data_r == '0) begin
          mem_we         = 1'b1;
          count_nxt      = count_r + MOD_W'(1);
          res_status_nxt = ST_INSERTED;
          res_slot_nxt   = s_r[SLOT_W-1:0];
          state_nxt      = S_RESP;
        end else if (mode_r == MODE_SEARCH &&
                     ((i_r != '0 && s_r == home_r) || rd_data_r == '0)) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else if (mode_r == MODE_SEARCH && rd_data_r == key_r) begin
          res_status_nxt = ST_FOUND;
          res_slot_nxt   = s_r[SLOT_W-1:0];
          state_nxt      = S_RESP;
        end else if (last_probe) begin
          res_status_nxt = {1'b0, 1'b0} | (mode_r == MODE_INSERT ? ST_FULL : ST_NOT_FOUND);
          state_nxt      = S_RESP;
        end else begin
          s_nxt     = addmod(s_r, d_r, m_r);
          d_nxt     = addmod(d_r, dd_r, m_r);
          i_nxt     = i_r + MOD_W'(1);
          state_nxt = S_READ;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = res_status_r;
          out_data_nxt.slot_index = res_slot_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_mod_r   <= MODULUS_RST;
      cfg_c1_r    <= LINEAR_RST;
      cfg_c2_r    <= SQUARE_RST;
      count_r     <= '0;
      clr_r       <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_mod_r   <= cfg_mod_nxt;
      cfg_c1_r    <= cfg_c1_nxt;
      cfg_c2_r    <= cfg_c2_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    m_r          <= m_nxt;
    s_r          <= s_nxt;
    home_r       <= home_nxt;
    d_r          <= d_nxt;
    dd_r         <= dd_nxt;
    c1m_r        <= c1m_nxt;
    c2m_r        <= c2m_nxt;
    i_r          <= i_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/qpht_checker.sv
// Port-level checks for the quadratic probe hash table, bound to the top level.
module qpht_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input qpht_pkg::out_item_t  out_data
);
  import qpht_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed or dropped while stalled");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL || out_data.status == ST_NOT_FOUND)
      |-> out_data.slot_index == '0)
    else $error("slot index nonzero on a miss");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the request finished");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready raised during the clearing pass");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
